FILE: hdl/igbp_pkg.sv
// Shared types and constants for the interaction graph balanced partition unit.
// Depends on nothing; imported by the top-level module.
package igbp_pkg;

  localparam int NQ        = 16;
  localparam int QW        = 4;
  localparam int MAX_PART  = 8;
  localparam int PW        = 3;
  localparam int EW        = 2 * QW;
  localparam int EDGES     = NQ * NQ;
  localparam int WW        = 16;
  localparam int DW        = 17;
  localparam int LW        = 5;
  localparam int CW        = 24;
  localparam int CFGW      = 4;

  localparam logic [WW-1:0] WEIGHT_MAX = {WW{1'b1}};
  localparam logic [DW-1:0] DEGREE_MAX = {DW{1'b1}};
  localparam logic [LW-1:0] LOAD_MAX   = {LW{1'b1}};
  localparam logic [CW-1:0] COST_MAX   = {CW{1'b1}};

  typedef struct packed {
    logic [QW-1:0] qubit_a;
    logic [QW-1:0] qubit_b;
    logic          last_pair;
  } in_item_t;

  typedef struct packed {
    logic [QW-1:0] qubit_index;
    logic [PW-1:0] partition_index;
    logic [CW-1:0] cut_cost;
    logic          is_cost;
    logic          last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PICK,
    ST_PART,
    ST_CUT,
    ST_CUTEND,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/interaction_graph_balanced_partition_unit.sv
// Top level of the interaction graph balanced partition unit.
// Depends on igbp_pkg; holds the edge weight memory and the partition sequencer.
//
//   channel | direction | handshake        | payload
//   in_     | input     | valid / stall    | in_item_t
//   out_    | output    | valid / stall    | out_item_t
//   cfg_    | input     | write enable     | num_partitions
//
// A plain interaction is a read of the edge weight memory, then its write-back;
// degrees are updated in the accept cycle.
// The item marked last then adds greedy placement over the active partitions,
// a cut scan, then 17 results.
// Reset clears control, degrees, loads and the edge valid bits.
// An output stall holds the result register; a new item is taken as soon as
// the final result has been loaded, even while it still waits.
module interaction_graph_balanced_partition_unit
  import igbp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_data,
  input  logic            cfg_we,
  input  logic [CFGW-1:0] cfg_wdata
);

  // Configuration register and its clamped value.
  logic [CFGW-1:0] num_part_r;
  logic [CFGW-1:0] parts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_part_r <= CFGW'(2);
    end else if (cfg_we) begin
      num_part_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (num_part_r == '0) begin
      parts = CFGW'(1);
    end else if (num_part_r > CFGW'(MAX_PART)) begin
      parts = CFGW'(MAX_PART);
    end else begin
      parts = num_part_r;
    end
  end

  // State and control registers.
  state_t            state_r, state_nxt;
  logic [EW-1:0]     idx_r;
  logic              last_r;
  logic [DW-1:0]     deg_r [NQ];
  logic [LW-1:0]     load_r [MAX_PART];
  logic [PW-1:0]     asg_r [NQ];
  logic [EDGES-1:0]  ev_r;
  logic [NQ-1:0]     placed_r;
  logic [QW:0]       n_r;
  logic [QW-1:0]     i_r;
  logic [QW-1:0]     best_r;
  logic [DW-1:0]     best_deg_r;
  logic              found_r;
  logic [CFGW-1:0]   p_r;
  logic [PW-1:0]     minp_r;
  logic [LW-1:0]     minload_r;
  logic [QW-1:0]     a_r, b_r;
  logic [PW-1:0]     asg_row_r;
  logic              pend_r, diff_r, vld_r;
  logic [CW-1:0]     cost_r;
  logic [QW:0]       q_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  // Edge weight memory with one registered read port.
  logic [WW-1:0]     emem [EDGES];
  logic [WW-1:0]     rdata_r;
  logic [EW-1:0]     raddr;
  logic              we;
  logic [WW-1:0]     wdata;

  // Input decode: order the pair, form the edge address.
  logic          accept;
  logic [QW-1:0] lo, hi;
  assign accept = in_valid && !in_stall;
  assign lo = (in_data.qubit_a < in_data.qubit_b) ? in_data.qubit_a : in_data.qubit_b;
  assign hi = (in_data.qubit_a < in_data.qubit_b) ? in_data.qubit_b : in_data.qubit_a;

  // Items are taken only when the sequencer is idle, so a read never
  // overlaps the write-back of the same entry.
  assign in_stall = (state_r != ST_IDLE);

  // Weight write-back during the load cycle.
  logic [WW-1:0] cur_w;
  assign cur_w = ev_r[idx_r] ? rdata_r : '0;
  assign we    = (state_r == ST_LOAD);
  assign wdata = (cur_w == WEIGHT_MAX) ? cur_w : cur_w + WW'(1);
  assign raddr = (state_r == ST_CUT) ? {a_r, b_r} : {lo, hi};

  always_ff @(posedge clk) begin
    if (we) begin
      emem[idx_r] <= wdata;
    end
    rdata_r <= emem[raddr];
  end

  // Greedy pick: candidate test for the qubit under scan.
  logic pick_take;
  assign pick_take = !placed_r[i_r] && (!found_r || deg_r[i_r] > best_deg_r);

  // Output register loading.
  logic out_load;
  assign out_load = !out_valid_r || !out_stall;

  // Cost accumulation of the registered read.
  logic [CW:0] cost_sum;
  assign cost_sum = {1'b0, cost_r} + (CW+1)'(rdata_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = last_r ? ST_PICK : ST_IDLE;
      ST_PICK:   if (i_r == QW'(NQ - 1)) state_nxt = ST_PART;
      ST_PART: begin
        if (p_r >= parts) begin
          state_nxt = (n_r == (QW+1)'(NQ - 1)) ? ST_CUT : ST_PICK;
        end
      end
      ST_CUT: begin
        if (a_r == QW'(NQ - 1) && b_r == QW'(NQ - 1)) state_nxt = ST_CUTEND;
      end
      ST_CUTEND: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load && q_r == (QW+1)'(NQ)) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath and stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r        <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      for (int k = 0; k < NQ; k++) deg_r[k] <= '0;
      for (int k = 0; k < MAX_PART; k++) load_r[k] <= '0;
    end else begin
      pend_r <= 1'b0;
      if (out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        // Accept: latch the edge and bump both degrees.
        ST_IDLE: begin
          if (accept) begin
            idx_r  <= {lo, hi};
            last_r <= in_data.last_pair;
            for (int k = 0; k < NQ; k++) begin
              logic [1:0]    inc;
              logic [DW:0]   dsum;
              inc  = {1'b0, lo == QW'(k)} + {1'b0, hi == QW'(k)};
              dsum = {1'b0, deg_r[k]} + (DW+1)'(inc);
              deg_r[k] <= (dsum > {1'b0, DEGREE_MAX}) ? DEGREE_MAX : dsum[DW-1:0];
            end
          end
        end
        // Write-back of the weight; start placement after the last item.
        ST_LOAD: begin
          ev_r[idx_r] <= 1'b1;
          i_r      <= '0;
          found_r  <= 1'b0;
          n_r      <= '0;
          placed_r <= '0;
        end
        // Scan unplaced qubits for the highest degree, lowest id.
        ST_PICK: begin
          if (pick_take) begin
            best_r     <= i_r;
            best_deg_r <= deg_r[i_r];
            found_r    <= 1'b1;
          end
          i_r       <= i_r + QW'(1);
          p_r       <= CFGW'(1);
          minp_r    <= '0;
          minload_r <= load_r[0];
        end
        // Scan partitions for the least load, then commit the qubit.
        ST_PART: begin
          if (p_r < parts) begin
            if (load_r[p_r[PW-1:0]] < minload_r) begin
              minp_r    <= p_r[PW-1:0];
              minload_r <= load_r[p_r[PW-1:0]];
            end
            p_r <= p_r + CFGW'(1);
          end else begin
            asg_r[best_r]    <= minp_r;
            if (minload_r != LOAD_MAX) load_r[minp_r] <= minload_r + LW'(1);
            placed_r[best_r] <= 1'b1;
            n_r     <= n_r + (QW+1)'(1);
            i_r     <= '0;
            found_r <= 1'b0;
            a_r     <= '0;
            b_r     <= '0;
            cost_r  <= '0;
          end
        end
        // Walk the upper triangle; the diagonal latches the row assignment.
        ST_CUT: begin
          pend_r <= 1'b1;
          vld_r  <= ev_r[{a_r, b_r}];
          if (b_r == a_r) begin
            diff_r    <= 1'b0;
            asg_row_r <= asg_r[b_r];
          end else begin
            diff_r <= (asg_row_r != asg_r[b_r]);
          end
          if (b_r == QW'(NQ - 1)) begin
            a_r <= a_r + QW'(1);
            b_r <= a_r + QW'(1);
          end else begin
            b_r <= b_r + QW'(1);
          end
        end
        ST_CUTEND: begin
          q_r <= '0;
        end
        // Stream assignments in id order, then the cost; clear on the last.
        ST_EMIT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            if (q_r == (QW+1)'(NQ)) begin
              out_data_r <= '{qubit_index: '0, partition_index: '0,
                              cut_cost: cost_r, is_cost: 1'b1, last_result: 1'b1};
              ev_r <= '0;
              for (int k = 0; k < NQ; k++) deg_r[k] <= '0;
              for (int k = 0; k < MAX_PART; k++) load_r[k] <= '0;
            end else begin
              out_data_r <= '{qubit_index: q_r[QW-1:0],
                              partition_index: asg_r[q_r[QW-1:0]],
                              cut_cost: '0, is_cost: 1'b0, last_result: 1'b0};
            end
            q_r <= q_r + (QW+1)'(1);
          end
        end
        default: ;
      endcase
      // Accumulate the weight read in the previous cycle.
      if (pend_r && vld_r && diff_r) begin
        cost_r <= cost_sum[CW] ? COST_MAX : cost_sum[CW-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer.
  a_pend_after_cut: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r) == ST_CUT)
    else $error("cut read pending outside cut scan");

  a_load_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD |-> $past(state_r) == ST_IDLE && $past(accept))
    else $error("write-back without an accepted item");

  a_part_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PART |-> p_r <= parts)
    else $error("partition scan out of range");

  a_placed_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PICK |-> $countones(placed_r) == n_r)
    else $error("placed count mismatch");

endmodule
